// File: src/ccc_pkg.sv
// Shared widths and pipeline control type for the coil combination block.
// No dependencies; used by ccc_cmul and coil_combine_conj_mac.
package ccc_pkg;

  localparam int VOXEL_W  = 16;
  localparam int SAMPLE_W = 16;
  localparam int MULT_W   = 2 * SAMPLE_W;
  localparam int PROD_W   = MULT_W + 1;
  localparam int ACC_W    = 40;

  typedef struct packed {
    logic               vld;
    logic               first;
    logic               last;
    logic [VOXEL_W-1:0] voxel;
  } ccc_ctl_t;

endpackage

// File: src/ccc_cmul.sv
// Two-stage multiply of a complex sample by the conjugate of a complex sensitivity.
// Depends on ccc_pkg for widths.
module ccc_cmul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [ccc_pkg::SAMPLE_W-1:0] img_re,
  input  logic signed [ccc_pkg::SAMPLE_W-1:0] img_im,
  input  logic signed [ccc_pkg::SAMPLE_W-1:0] sens_re,
  input  logic signed [ccc_pkg::SAMPLE_W-1:0] sens_im,
  output logic signed [ccc_pkg::PROD_W-1:0]   prod_re,
  output logic signed [ccc_pkg::PROD_W-1:0]   prod_im
);

  logic signed [ccc_pkg::MULT_W-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r;
  logic signed [ccc_pkg::PROD_W-1:0] prod_re_r, prod_im_r;
  logic signed [ccc_pkg::PROD_W-1:0] prod_re_nxt, prod_im_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      p_rr_r <= img_re * sens_re;
      p_ii_r <= img_im * sens_im;
      p_ir_r <= img_im * sens_re;
      p_ri_r <= img_re * sens_im;
    end
  end

  // re = ir*sr + ii*si, im = ii*sr - ir*si
  always_comb begin
    prod_re_nxt = {p_rr_r[ccc_pkg::MULT_W-1], p_rr_r} + {p_ii_r[ccc_pkg::MULT_W-1], p_ii_r};
    prod_im_nxt = {p_ir_r[ccc_pkg::MULT_W-1], p_ir_r} - {p_ri_r[ccc_pkg::MULT_W-1], p_ri_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_re_r <= prod_re_nxt;
      prod_im_r <= prod_im_nxt;
    end
  end

  assign prod_re = prod_re_r;
  assign prod_im = prod_im_r;

endmodule

// File: src/coil_combine_conj_mac.sv
// Adjoint coil combination: accumulates img * conj(sens) per voxel address.
// Depends on ccc_pkg and ccc_cmul.
//
// Input stream (in_*): one coil sample per transfer with its sensitivity,
// voxel address, in_tuser = first-coil flag, in_tlast = last-coil flag.
// A first-coil transfer overwrites the voxel's accumulator, later ones add.
// Output stream (out_*): one transfer per last-coil input, carrying the
// voxel address and the 40-bit complex sum.
// Throughput: one input transfer per cycle, sustained while the output is not stalled.
// Pipeline: an accepted transfer passes the input register, two multiply
// stages, the accumulator read and the output register before out_tvalid.
// Accumulator RAM read is issued one stage ahead of the update; the
// previous write is forwarded, so back-to-back hits on one voxel are exact.
// Addresses at or above VOXEL_COUNT wrap modulo VOXEL_COUNT for the store.
// Reset clears all valid bits; the accumulator store is not cleared, so
// each voxel must start with a first-coil transfer.
// A stalled output (out_tvalid high while out_tready is low) freezes the whole pipeline and drops
// in_tready; nothing is lost or repeated.
module coil_combine_conj_mac #(
  parameter int VOXEL_COUNT = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // voxel[15:0], img_re[31:16], img_im[47:32], sens_re[63:48], sens_im[79:64]
  input  logic [79:0] in_tdata,
  // coil_first[0]
  input  logic        in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // voxel_out[15:0], sum_re[55:16], sum_im[95:56]
  output logic [95:0] out_tdata
);

  localparam int IDX_W = (VOXEL_COUNT > 1) ? $clog2(VOXEL_COUNT) : 1;
  localparam int VW    = ccc_pkg::VOXEL_W;
  localparam int AW    = ccc_pkg::ACC_W;
  localparam int PW    = ccc_pkg::PROD_W;
  localparam int DW    = VW + 21;
  localparam int RW    = VW + 2;
  localparam int RS    = VW + IDX_W;
  localparam logic [RW-1:0] RM = RW'((64'd1 << RS) / 64'(VOXEL_COUNT));

  logic en;

  ccc_pkg::ccc_ctl_t s1_r, s2_r, s3_r, s4_r;
  ccc_pkg::ccc_ctl_t s1_nxt;

  logic signed [ccc_pkg::SAMPLE_W-1:0] s1_img_re_r, s1_img_im_r, s1_sens_re_r, s1_sens_im_r;
  logic [VW+RW-1:0] s2_mul;
  logic [VW-1:0]    s2_quo_r, s2_quo_nxt;
  logic [DW-1:0]    s3_rem;
  logic [IDX_W-1:0] s3_idx_r, s3_idx_nxt, s4_idx_r;

  logic signed [PW-1:0] prod_re, prod_im;
  logic [AW-1:0] s4_pre_r, s4_pim_r;

  logic [2*AW-1:0] mem [VOXEL_COUNT];
  logic [2*AW-1:0] rd_r;

  logic             wr_vld_r;
  logic [IDX_W-1:0] wr_idx_r;
  logic [2*AW-1:0]  wr_sum_r;
  logic             fwd_hit;
  logic [AW-1:0]    base_re, base_im, sum_re_nxt, sum_im_nxt;
  logic             wr_en;

  logic          out_tvalid_r, out_tvalid_nxt;
  logic [VW-1:0] out_voxel_r;
  logic [AW-1:0] out_re_r, out_im_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  always_comb begin
    s1_nxt.vld   = in_tvalid;
    s1_nxt.first = in_tuser;
    s1_nxt.last  = in_tlast;
    s1_nxt.voxel = in_tdata[15:0];
  end

  // valid bits and payload along the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      s2_r.vld <= 1'b0;
      s3_r.vld <= 1'b0;
      s4_r.vld <= 1'b0;
    end else if (en) begin
      s1_r.vld     <= s1_nxt.vld;
      s2_r.vld     <= s1_r.vld;
      s3_r.vld     <= s2_r.vld;
      s4_r.vld     <= s3_r.vld;
      s1_r.first   <= s1_nxt.first;
      s1_r.last    <= s1_nxt.last;
      s1_r.voxel   <= s1_nxt.voxel;
      s1_img_re_r  <= in_tdata[31:16];
      s1_img_im_r  <= in_tdata[47:32];
      s1_sens_re_r <= in_tdata[63:48];
      s1_sens_im_r <= in_tdata[79:64];
      s2_r.first   <= s1_r.first;
      s2_r.last    <= s1_r.last;
      s2_r.voxel   <= s1_r.voxel;
      s2_quo_r     <= s2_quo_nxt;
      s3_r.first   <= s2_r.first;
      s3_r.last    <= s2_r.last;
      s3_r.voxel   <= s2_r.voxel;
      s3_idx_r     <= s3_idx_nxt;
      s4_r.first   <= s3_r.first;
      s4_r.last    <= s3_r.last;
      s4_r.voxel   <= s3_r.voxel;
      s4_idx_r     <= s3_idx_r;
      s4_pre_r     <= {{(AW-PW){prod_re[PW-1]}}, prod_re};
      s4_pim_r     <= {{(AW-PW){prod_im[PW-1]}}, prod_im};
    end
  end

  // address modulo VOXEL_COUNT: reciprocal quotient, low by at most one
  always_comb begin : recip_quo
    s2_mul     = (VW+RW)'(s1_r.voxel) * (VW+RW)'(RM);
    s2_quo_nxt = VW'(s2_mul >> RS);
  end

  // remainder with one correction step
  always_comb begin : recip_rem
    s3_rem = DW'(s2_r.voxel) - DW'(s2_quo_r) * DW'(VOXEL_COUNT);
    if (s3_rem >= DW'(VOXEL_COUNT)) s3_rem = s3_rem - DW'(VOXEL_COUNT);
    s3_idx_nxt = s3_rem[IDX_W-1:0];
  end

  ccc_cmul u_cmul (
    .clk     (clk),
    .en      (en),
    .img_re  (s1_img_re_r),
    .img_im  (s1_img_im_r),
    .sens_re (s1_sens_re_r),
    .sens_im (s1_sens_im_r),
    .prod_re (prod_re),
    .prod_im (prod_im)
  );

  // accumulator store: {imag, real}
  always_ff @(posedge clk) begin
    if (en) rd_r <= mem[s3_idx_r];
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[s4_idx_r] <= {sum_im_nxt, sum_re_nxt};
  end

  // write issued on the same edge as the read is not seen by it
  always_comb begin
    fwd_hit = wr_vld_r && (wr_idx_r == s4_idx_r);
    if (s4_r.first) begin
      base_re = '0;
      base_im = '0;
    end else if (fwd_hit) begin
      base_re = wr_sum_r[AW-1:0];
      base_im = wr_sum_r[2*AW-1:AW];
    end else begin
      base_re = rd_r[AW-1:0];
      base_im = rd_r[2*AW-1:AW];
    end
    sum_re_nxt = base_re + s4_pre_r;
    sum_im_nxt = base_im + s4_pim_r;
    wr_en      = en && s4_r.vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_vld_r <= 1'b0;
    end else if (wr_en) begin
      wr_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wr_idx_r <= s4_idx_r;
      wr_sum_r <= {sum_im_nxt, sum_re_nxt};
    end
  end

  // output register
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (en) out_tvalid_nxt = s4_r.vld && s4_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s4_r.vld && s4_r.last) begin
      out_voxel_r <= s4_r.voxel;
      out_re_r    <= sum_re_nxt;
      out_im_r    <= sum_im_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_im_r, out_re_r, out_voxel_r};

`ifndef SYNTH
  a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(s4_r.vld && s4_r.last))
    else $error("output raised without a last-coil item");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s4_r) && $stable(s4_idx_r))
    else $error("update stage moved during a stall");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_r.vld |-> (32'(s3_idx_r) < VOXEL_COUNT))
    else $error("store index out of range");
`endif

endmodule

// File: dv/coil_combine_conj_mac_tb.sv
// Self-checking testbench for coil_combine_conj_mac: streams coil samples,
// predicts each voxel's conjugate-product sum and checks every output transfer.
// Depends on ccc_pkg and the coil_combine_conj_mac RTL.
`timescale 1ns / 1ps

module coil_combine_conj_mac_tb;

  localparam int VOXEL_W  = ccc_pkg::VOXEL_W;
  localparam int SAMPLE_W = ccc_pkg::SAMPLE_W;
  localparam int ACC_W    = ccc_pkg::ACC_W;

  localparam int TOTAL_ITEMS = 700;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 5000;
  localparam int WRAP_ADDS   = 280;
  localparam logic [VOXEL_W-1:0] WRAP_VOX = 16'hC0DE;
  localparam logic signed [SAMPLE_W-1:0] Q15_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] Q15_MAX = 16'sh7FFF;

  typedef struct {
    logic [VOXEL_W-1:0]         voxel;
    logic                       first;
    logic                       last;
    logic signed [SAMPLE_W-1:0] img_re;
    logic signed [SAMPLE_W-1:0] img_im;
    logic signed [SAMPLE_W-1:0] sens_re;
    logic signed [SAMPLE_W-1:0] sens_im;
  } coil_t;

  typedef struct {
    logic [VOXEL_W-1:0] voxel;
    logic [ACC_W-1:0]   sum_re;
    logic [ACC_W-1:0]   sum_im;
  } voxel_sum_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;

  coil_t      coil_q[$];
  voxel_sum_t voxel_sum_q[$];
  logic [ACC_W-1:0] sum_re_mem [0:65535];
  logic [ACC_W-1:0] sum_im_mem [0:65535];

  int total_items = TOTAL_ITEMS;
  int in_xfer_cnt = 0;
  int sums_checked = 0;
  int wrap_sums = 0;
  int err_cnt = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  coil_combine_conj_mac DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic bit idle_on();
    return ((in_xfer_cnt / 50) % 4 != 3) && (in_xfer_cnt + 120 < total_items);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_q15();
    case ($urandom_range(0, 9))
      0: return Q15_MIN;
      1: return Q15_MAX;
      2: return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [VOXEL_W-1:0] rand_voxel();
    logic [VOXEL_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = VOXEL_W'($urandom_range(0, 15));
      5: v = '1;
      6: v = '0;
      default: v = VOXEL_W'($urandom);
    endcase
    if (v == WRAP_VOX) v = v ^ 16'h0001;
    return v;
  endfunction

  task automatic add_coil(input logic [VOXEL_W-1:0] v, input logic f, input logic l,
                          input logic signed [SAMPLE_W-1:0] ir, input logic signed [SAMPLE_W-1:0] ii,
                          input logic signed [SAMPLE_W-1:0] sr, input logic signed [SAMPLE_W-1:0] si);
    coil_t c;
    c.voxel = v;
    c.first = f;
    c.last = l;
    c.img_re = ir;
    c.img_im = ii;
    c.sens_re = sr;
    c.sens_im = si;
    coil_q.push_back(c);
  endtask

  task automatic add_rand_coil(input logic [VOXEL_W-1:0] v, input logic f, input logic l);
    add_coil(v, f, l, rand_q15(), rand_q15(), rand_q15(), rand_q15());
  endtask

  // sum += img * conj(sens), restarted on a first coil; 40-bit wrap on overflow
  function automatic void fold_coil(input coil_t c);
    longint     pr;
    longint     pi;
    voxel_sum_t s;
    pr = longint'(c.img_re) * longint'(c.sens_re) + longint'(c.img_im) * longint'(c.sens_im);
    pi = longint'(c.img_im) * longint'(c.sens_re) - longint'(c.img_re) * longint'(c.sens_im);
    if (c.first) begin
      sum_re_mem[c.voxel] = pr[ACC_W-1:0];
      sum_im_mem[c.voxel] = pi[ACC_W-1:0];
    end else begin
      sum_re_mem[c.voxel] = sum_re_mem[c.voxel] + pr[ACC_W-1:0];
      sum_im_mem[c.voxel] = sum_im_mem[c.voxel] + pi[ACC_W-1:0];
    end
    if (c.last) begin
      s.voxel = c.voxel;
      s.sum_re = sum_re_mem[c.voxel];
      s.sum_im = sum_im_mem[c.voxel];
      voxel_sum_q.push_back(s);
    end
  endfunction

  // Driver
  always @(posedge clk) begin
    coil_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (idle_on() && hold_left == 0 && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(0, 17);
        in_tvalid <= 1'b0;
      end else if (coil_q.size() > 0) begin
        c = coil_q.pop_front();
        in_tdata <= {c.sens_im, c.sens_re, c.img_im, c.img_re, c.voxel};
        in_tuser <= c.first;
        in_tlast <= c.last;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result sink: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && in_xfer_cnt >= 150) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on() && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(0, 17);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: predict on input transfers, check output transfers
  always @(posedge clk) begin
    coil_t              c;
    voxel_sum_t         want;
    logic [VOXEL_W-1:0] got_vox;
    logic [ACC_W-1:0]   got_re;
    logic [ACC_W-1:0]   got_im;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        c.voxel = in_tdata[15:0];
        c.img_re = in_tdata[31:16];
        c.img_im = in_tdata[47:32];
        c.sens_re = in_tdata[63:48];
        c.sens_im = in_tdata[79:64];
        c.first = in_tuser;
        c.last = in_tlast;
        fold_coil(c);
        in_xfer_cnt <= in_xfer_cnt + 1;
      end
      if (out_tvalid && out_tready) begin
        got_vox = out_tdata[15:0];
        got_re = out_tdata[55:16];
        got_im = out_tdata[95:56];
        if (voxel_sum_q.size() == 0) begin
          $error("unexpected result: voxel_out=%h sum_re=%h sum_im=%h", got_vox, got_re, got_im);
          err_cnt++;
        end else begin
          want = voxel_sum_q.pop_front();
          sums_checked++;
          if (got_vox !== want.voxel) begin
            $error("voxel_out: expected %h, got %h", want.voxel, got_vox);
            err_cnt++;
          end
          if (got_re !== want.sum_re) begin
            $error("sum_re (voxel %h): expected %h, got %h", want.voxel, want.sum_re, got_re);
            err_cnt++;
          end
          if (got_im !== want.sum_im) begin
            $error("sum_im (voxel %h): expected %h, got %h", want.voxel, want.sum_im, got_im);
            err_cnt++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    logic [VOXEL_W-1:0] open_vox[$];
    int                 open_left[$];
    logic [VOXEL_W-1:0] done_vox[$];
    logic [VOXEL_W-1:0] v;
    int                 pick;
    int                 k;
    int                 wrap_left;

    // directed: extremes, flag combinations, hazards on one voxel
    add_coil(16'h0000, 1, 1, Q15_MIN, Q15_MIN, Q15_MIN, Q15_MIN);
    add_coil(16'hFFFF, 1, 1, Q15_MAX, Q15_MAX, Q15_MAX, Q15_MAX);
    add_coil(16'hFFFF, 0, 0, Q15_MIN, Q15_MAX, Q15_MAX, Q15_MIN);
    add_coil(16'hFFFF, 0, 1, Q15_MAX, Q15_MIN, Q15_MIN, Q15_MAX);
    add_coil(16'h5A5A, 1, 0, Q15_MAX, Q15_MIN, Q15_MIN, Q15_MAX);
    add_coil(16'h5A5A, 0, 0, Q15_MIN, Q15_MAX, Q15_MAX, Q15_MIN);
    add_coil(16'h5A5A, 0, 0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    add_coil(16'h5A5A, 0, 1, 16'sd1, -16'sd1, -16'sd1, 16'sd1);
    add_coil(16'h5A5A, 0, 1, Q15_MIN, Q15_MIN, Q15_MIN, Q15_MIN);
    add_coil(16'hA5A5, 1, 0, Q15_MAX, Q15_MAX, Q15_MIN, Q15_MIN);
    add_coil(16'hA5A5, 1, 1, -16'sd1, -16'sd1, Q15_MAX, Q15_MIN);
    add_coil(16'h0001, 1, 0, 16'sd100, -16'sd200, 16'sd300, -16'sd400);
    add_coil(16'h0001, 0, 0, Q15_MAX, Q15_MAX, Q15_MAX, Q15_MAX);
    add_coil(16'h0001, 0, 0, Q15_MIN, Q15_MIN, Q15_MAX, Q15_MAX);
    add_coil(16'h0001, 0, 0, 16'sh1234, -16'sh4321, 16'sh7654, -16'sh0F0F);
    add_coil(16'h0001, 0, 1, Q15_MAX, Q15_MIN, Q15_MAX, Q15_MIN);
    add_coil(16'h0002, 1, 0, 16'sh2000, 16'sh2000, 16'sh2000, 16'sh2000);
    add_coil(16'h0003, 1, 0, Q15_MIN, 16'sh0001, Q15_MIN, 16'sh0001);
    add_coil(16'h0002, 0, 1, -16'sh2000, 16'sh2000, -16'sh2000, 16'sh2000);
    add_coil(16'h0003, 0, 0, Q15_MAX, Q15_MIN, 16'sd0, Q15_MAX);
    add_coil(16'h0003, 0, 1, 16'sd7, -16'sd7, 16'sd7, -16'sd7);
    done_vox = '{16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5, 16'h0001, 16'h0002, 16'h0003};

    // one voxel fed maximum products until its sum wraps past 40 bits
    add_coil(WRAP_VOX, 1, 0, Q15_MIN, Q15_MIN, Q15_MIN, Q15_MIN);
    wrap_left = WRAP_ADDS;

    while (coil_q.size() < TOTAL_ITEMS - 20) begin
      pick = $urandom_range(0, 99);
      if (wrap_left > 0 && pick < 42) begin
        wrap_left--;
        add_coil(WRAP_VOX, 0, (wrap_left % 30) == 0, Q15_MIN, Q15_MIN, Q15_MIN, Q15_MIN);
        if ((wrap_left % 30) == 0) wrap_sums++;
      end else if (pick >= 90) begin
        // stray add or emit on a voxel that already holds a sum
        v = done_vox[$urandom_range(0, done_vox.size() - 1)];
        add_rand_coil(v, 1'b0, 1'($urandom_range(0, 1)));
      end else if (pick >= 86 && open_vox.size() > 0) begin
        // run abandoned without its last coil
        k = $urandom_range(0, open_vox.size() - 1);
        done_vox.push_back(open_vox[k]);
        open_vox.delete(k);
        open_left.delete(k);
      end else if (open_vox.size() == 0 || (open_vox.size() < 4 && pick >= 70)) begin
        v = rand_voxel();
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
        add_rand_coil(v, 1'b1, k == 1);
        if (k == 1) begin
          done_vox.push_back(v);
        end else begin
          open_vox.push_back(v);
          open_left.push_back(k - 1);
        end
      end else begin
        k = pick[0] ? 0 : $urandom_range(0, open_vox.size() - 1);
        open_left[k]--;
        add_rand_coil(open_vox[k], 1'b0, open_left[k] == 0);
        if (open_left[k] == 0) begin
          done_vox.push_back(open_vox[k]);
          open_vox.delete(k);
          open_left.delete(k);
        end
      end
      if (done_vox.size() > 24) void'(done_vox.pop_front());
    end
    while (wrap_left > 0) begin
      wrap_left--;
      add_coil(WRAP_VOX, 0, 1'b0, Q15_MIN, Q15_MIN, Q15_MIN, Q15_MIN);
    end
    add_rand_coil(WRAP_VOX, 1'b0, 1'b1);
    wrap_sums++;
    foreach (open_vox[i]) add_rand_coil(open_vox[i], 1'b0, 1'b1);
    total_items = coil_q.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (in_xfer_cnt < total_items);
    do @(negedge clk); while (voxel_sum_q.size() != 0);
    repeat (16) @(negedge clk);

    $display("coverage: %0d coil transfers, %0d voxel sums checked (%0d on the wrapping voxel)",
             in_xfer_cnt, sums_checked, wrap_sums);
    $display("          random idling on both sides and one %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (err_cnt == 0 && voxel_sum_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/ccc_pkg.sv
src/ccc_cmul.sv
src/coil_combine_conj_mac.sv
dv/coil_combine_conj_mac_tb.sv
